### rtl/positional_list_engine_macros.svh
// Assertion macros shared by the positional list engine RTL.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger.
`define PLE_ASSERT_SAME(name, clk, rst, trig, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (trig) |-> (prop)) \
      else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define PLE_ASSERT_NEXT(name, clk, rst, trig, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
      else $error(msg);

`endif

### rtl/ple_pkg.sv
// Types and constants shared by the positional list engine modules.
`timescale 1ns / 1ps
package ple_pkg;

   localparam int POS_W      = 7;
   localparam int VALUE_W    = 32;
   localparam int TAG_W      = 7;
   localparam int LEN_W      = 7;
   localparam int KIND_W     = 2;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT = 2'd0,
      KIND_DELETE = 2'd1,
      KIND_READ   = 2'd2,
      KIND_CLEAR  = 2'd3
   } ple_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE    = 2'd0,
      ST_BAD_POS = 2'd1,
      ST_FULL    = 2'd2
   } ple_status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;     // latch the incoming request and decode it
      logic shift;    // move one entry per cycle
      logic put;      // write the new entry into its slot
      logic finish;   // load the response register
   } ple_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic ins_ok;        // incoming insert is accepted
      logic moves_zero;    // incoming request needs no entry moves
      logic del_move;      // incoming delete is accepted and needs moves
      logic ins_latched;   // request in progress is an insert
      logic moves_done;    // last entry move is written this cycle
      logic out_free;      // response register can take a new response
   } ple_stat_type;

endpackage

### rtl/ple_ram.sv
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module ple_ram #(
   parameter int WIDTH = 39,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### rtl/ple_controller.sv
// Sequencing state machine of the positional list engine.
`timescale 1ns / 1ps
module ple_controller import ple_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  ple_stat_type stat,
   output ple_cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SHIFT,
      S_PUT,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   always_comb begin
      cmd.take   = ready_ff && req_tvalid;
      cmd.shift  = (state_ff == S_SHIFT);
      cmd.put    = (state_ff == S_PUT);
      cmd.finish = (state_ff == S_DONE) && stat.out_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.take) begin
               if (stat.ins_ok) begin
                  state_in = stat.moves_zero ? S_PUT : S_SHIFT;
               end else if (stat.del_move) begin
                  state_in = S_SHIFT;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SHIFT: begin
            if (stat.moves_done) begin
               state_in = stat.ins_latched ? S_PUT : S_DONE;
            end
         end
         S_PUT: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      ready_in = (state_in == S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_tready = ready_ff;

endmodule

### rtl/ple_datapath.sv
// Entry memory, length counter, move pointers and response register.
`timescale 1ns / 1ps
module ple_datapath import ple_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ple_kind_type              req_kind,
   input  logic [POS_W-1:0]          req_position,
   input  logic signed [VALUE_W-1:0] req_value,
   input  ple_cmd_type               cmd,
   output ple_stat_type              stat,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output ple_status_type            rsp_status,
   output logic signed [VALUE_W-1:0] rsp_entry_value,
   output logic [TAG_W-1:0]          rsp_entry_tag,
   output logic [LEN_W-1:0]          rsp_length
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;
   localparam int EW   = TAG_W + VALUE_W;

   // Control state
   logic [CW-1:0]  count_ff, count_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           mv_pend_ff, mv_pend_in;

   // Request in progress
   ple_status_type             status_ff, status_in;
   logic                       read_ok_ff, read_ok_in;
   logic                       ins_op_ff, ins_op_in;
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic signed [VALUE_W-1:0]  value_ff, value_in;
   logic [CW-1:0]              rem_ff, rem_in;
   logic [AW-1:0]              src_ff, src_in;
   logic [AW-1:0]              dst_ff, dst_in;

   // Response register
   ple_status_type             rsp_status_ff, rsp_status_in;
   logic signed [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [TAG_W-1:0]           rsp_tag_ff, rsp_tag_in;
   logic [LEN_W-1:0]           rsp_len_ff, rsp_len_in;

   // Decode of the incoming request
   logic [CMPW-1:0] pos_w, cnt_w, moves;
   logic            pos_zero, bad_ins, bad_other, full;
   logic            ins_go, del_go, rd_go;
   ple_status_type  status_now;

   // Memory ports
   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [EW-1:0] wr_data, ram_q;

   ple_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   always_comb begin
      pos_w     = CMPW'(req_position);
      cnt_w     = CMPW'(count_ff);
      pos_zero  = (req_position == '0);
      bad_ins   = pos_zero || (pos_w > (cnt_w + CMPW'(1)));
      bad_other = pos_zero || (pos_w > cnt_w);
      full      = (count_ff == CW'(DEPTH));
      case (req_kind)
         KIND_INSERT: begin
            status_now = bad_ins ? ST_BAD_POS : (full ? ST_FULL : ST_DONE);
         end
         KIND_DELETE, KIND_READ: begin
            status_now = bad_other ? ST_BAD_POS : ST_DONE;
         end
         default: begin
            status_now = ST_DONE;
         end
      endcase
      ins_go = (req_kind == KIND_INSERT) && (status_now == ST_DONE);
      del_go = (req_kind == KIND_DELETE) && (status_now == ST_DONE);
      rd_go  = (req_kind == KIND_READ) && (status_now == ST_DONE);
      moves  = (req_kind == KIND_INSERT) ? (cnt_w - pos_w + CMPW'(1)) : (cnt_w - pos_w);
   end

   always_comb begin
      stat.ins_ok      = ins_go;
      stat.moves_zero  = (moves == '0);
      stat.del_move    = del_go && (moves != '0);
      stat.ins_latched = ins_op_ff;
      stat.moves_done  = (rem_ff == '0) && mv_pend_ff;
      stat.out_free    = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      mv_pend_in    = mv_pend_ff;
      status_in     = status_ff;
      read_ok_in    = read_ok_ff;
      ins_op_in     = ins_op_ff;
      pos_in        = pos_ff;
      value_in      = value_ff;
      rem_in        = rem_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_len_in    = rsp_len_ff;
      wr_en         = 1'b0;
      wr_addr       = dst_ff;
      wr_data       = ram_q;
      rd_en         = 1'b0;
      rd_addr       = src_ff;

      if (cmd.take) begin
         status_in  = status_now;
         read_ok_in = rd_go;
         ins_op_in  = (req_kind == KIND_INSERT);
         pos_in     = req_position;
         value_in   = req_value;
         rem_in     = CW'(moves);
         // Inserts move the tail back starting at the end, deletes pull it forward
         src_in     = (req_kind == KIND_INSERT) ? AW'(cnt_w - CMPW'(1)) : AW'(pos_w);
         if (ins_go) begin
            count_in = count_ff + CW'(1);
         end else if (del_go) begin
            count_in = count_ff - CW'(1);
         end else if (req_kind == KIND_CLEAR) begin
            count_in = '0;
         end
         if (rd_go) begin
            rd_en   = 1'b1;
            rd_addr = AW'(pos_w - CMPW'(1));
         end
      end

      if (cmd.shift) begin
         if (rem_ff != '0) begin
            rd_en      = 1'b1;
            rd_addr    = src_ff;
            src_in     = ins_op_ff ? (src_ff - AW'(1)) : (src_ff + AW'(1));
            dst_in     = ins_op_ff ? (src_ff + AW'(1)) : (src_ff - AW'(1));
            rem_in     = rem_ff - CW'(1);
            mv_pend_in = 1'b1;
         end else begin
            mv_pend_in = 1'b0;
         end
         if (mv_pend_ff) begin
            wr_en   = 1'b1;
            wr_addr = dst_ff;
            wr_data = ram_q;
         end
      end

      if (cmd.put) begin
         wr_en   = 1'b1;
         wr_addr = AW'(CMPW'(pos_ff) - CMPW'(1));
         wr_data = {pos_ff, value_ff};
      end

      if (cmd.finish) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_value_in  = read_ok_ff ? signed'(ram_q[VALUE_W-1:0]) : '0;
         rsp_tag_in    = read_ok_ff ? ram_q[EW-1:VALUE_W] : '0;
         rsp_len_in    = LEN_W'(count_ff);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         mv_pend_ff   <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         mv_pend_ff   <= mv_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      read_ok_ff    <= read_ok_in;
      ins_op_ff     <= ins_op_in;
      pos_ff        <= pos_in;
      value_ff      <= value_in;
      rem_ff        <= rem_in;
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_len_ff    <= rsp_len_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_value = rsp_value_ff;
   assign rsp_entry_tag   = rsp_tag_ff;
   assign rsp_length      = rsp_len_ff;

endmodule

### rtl/positional_list_engine.sv
// Top level of the positional list engine: stream ports, controller and datapath.
`timescale 1ns / 1ps
`include "positional_list_engine_macros.svh"
// Ordered list of up to DEPTH entries, each a signed 32-bit value and the 7-bit
// tag that was the position named at insertion. Each request carries a kind in
// req_tuser (insert, delete, read, clear) and a 1-based position and value in
// req_tdata; each request yields exactly one response with a status in
// rsp_tuser (done, invalid position, list full) and the read value, read tag
// and list length in rsp_tdata. Value and tag are zero except for a successful
// read; length is reported in its low 7 bits. A bad position or an insert into
// a full list changes nothing; a clear always succeeds. Requests are handled
// one at a time: clear, read, rejected requests and a delete of the last entry
// respond straight after decode, an insert moves the tail, then writes the
// new entry (only writes when it appends), and a delete that moves entries
// moves the tail first. The entry memory has one write port, so the tail of
// the list moves one entry per cycle. A finished response sits in an output
// register, so the block returns to accepting requests while the response
// waits for rsp_tready. Entries are undefined after reset; no clearing pass
// is needed since only entries below the length are ever read.
module positional_list_engine import ple_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [KIND_W-1:0]     req_tuser,    // [1:0] kind
   input  logic [REQ_DATA_W-1:0] req_tdata,    // [6:0] position, [38:7] value, [39] zero
   // Response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [STATUS_W-1:0]   rsp_tuser,    // [1:0] status
   output logic [RSP_DATA_W-1:0] rsp_tdata     // [31:0] entry_value, [38:32] entry_tag,
                                               // [45:39] length, [47:46] zero
);

   localparam int RSP_PAD_W = RSP_DATA_W - VALUE_W - TAG_W - LEN_W;

   ple_cmd_type               cmd;
   ple_stat_type              stat;
   ple_kind_type              req_kind;
   logic [POS_W-1:0]          req_position;
   logic signed [VALUE_W-1:0] req_value;
   ple_status_type            rsp_status;
   logic signed [VALUE_W-1:0] rsp_entry_value;
   logic [TAG_W-1:0]          rsp_entry_tag;
   logic [LEN_W-1:0]          rsp_length;

   // Unpack request fields
   assign req_kind     = ple_kind_type'(req_tuser);
   assign req_position = req_tdata[POS_W-1:0];
   assign req_value    = signed'(req_tdata[POS_W+VALUE_W-1:POS_W]);

   // Sequence each request: decode, move the tail, write the new entry, respond
   ple_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Hold the list, its length and the response register
   ple_datapath #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_kind        (req_kind),
      .req_position    (req_position),
      .req_value       (req_value),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_ready       (rsp_tready),
      .rsp_valid       (rsp_tvalid),
      .rsp_status      (rsp_status),
      .rsp_entry_value (rsp_entry_value),
      .rsp_entry_tag   (rsp_entry_tag),
      .rsp_length      (rsp_length)
   );

   // Pack response fields
   assign rsp_tuser = rsp_status;
   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_length, rsp_entry_tag, rsp_entry_value};

   // A request in progress blocks the next one
   `PLE_ASSERT_NEXT(a_busy_after_take, clock, reset, req_tvalid && req_tready, !req_tready, "request accepted while busy")
   // Never overwrite a response that has not been taken
   `PLE_ASSERT_SAME(a_finish_free, clock, reset, cmd.finish, stat.out_free, "response register overrun")
   // At most one datapath command per cycle
   `PLE_ASSERT_SAME(a_cmd_onehot, clock, reset, 1'b1, $onehot0(cmd), "conflicting datapath commands")
   // A response is loaded only once per request
   `PLE_ASSERT_NEXT(a_single_finish, clock, reset, cmd.finish, !cmd.finish, "repeated response")

endmodule

### tb/sv/positional_list_engine_test.sv
// Self-checking testbench for the positional list engine stream block.
`timescale 1ns / 1ps
module positional_list_engine_test;
   import ple_pkg::*;

   // Matches the DEPTH of the instance below.
   localparam int DEPTH        = 64;
   // The slowest request is an insert at the head of a 63-entry list.
   // Allow well over its duration per request, with the receiver stalling on top.
   localparam int CYCLE_LIMIT  = 800000;
   // Settle time after the last response, longer than any single request.
   localparam int DRAIN_CYCLES = 100;

   // Expected contents of one response.
   typedef struct packed {
      ple_status_type status;
      logic [31:0]    value;
      logic [6:0]     tag;
      logic [6:0]     length;
   } list_result_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [KIND_W-1:0]     req_tuser;    // [1:0] kind
   logic [REQ_DATA_W-1:0] req_tdata;    // [6:0] position, [38:7] value, [39] zero
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [STATUS_W-1:0]   rsp_tuser;    // [1:0] status
   logic [RSP_DATA_W-1:0] rsp_tdata;    // [31:0] value, [38:32] tag, [45:39] length

   // Shadow copy of the list, updated as each request is accepted.
   logic [31:0]     entry_vals [DEPTH];
   logic [6:0]      entry_tags [DEPTH];
   int              list_len;
   list_result_type pending_results [$];

   // When set, neither side inserts idle cycles.
   bit steady;
   int errors;
   int cycle_count;
   int kind_count [4];
   int status_count [3];
   int longest_list;

   positional_list_engine #(.DEPTH(DEPTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Apply one request to the shadow list and return the response it must produce.
   // Position checks come before the full check; a clear ignores the position.
   function automatic list_result_type apply_request(ple_kind_type kind, logic [6:0] pos,
                                                     logic [31:0] val);
      list_result_type res;
      int i;
      res.status = ST_DONE;
      res.value  = '0;
      res.tag    = '0;
      case (kind)
         KIND_INSERT: begin
            if (pos == 0 || pos > list_len + 1) begin
               res.status = ST_BAD_POS;
            end else if (list_len >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               // Move the tail back by one to open the slot.
               for (i = list_len; i > pos - 1; i--) begin
                  entry_vals[i] = entry_vals[i-1];
                  entry_tags[i] = entry_tags[i-1];
               end
               entry_vals[pos-1] = val;
               entry_tags[pos-1] = pos;
               list_len++;
            end
         end
         KIND_DELETE: begin
            if (pos == 0 || pos > list_len) begin
               res.status = ST_BAD_POS;
            end else begin
               // Close the gap; a head delete removes only the first entry.
               for (i = pos - 1; i + 1 < list_len; i++) begin
                  entry_vals[i] = entry_vals[i+1];
                  entry_tags[i] = entry_tags[i+1];
               end
               list_len--;
            end
         end
         KIND_READ: begin
            if (pos == 0 || pos > list_len) begin
               res.status = ST_BAD_POS;
            end else begin
               res.value = entry_vals[pos-1];
               res.tag   = entry_tags[pos-1];
            end
         end
         default: list_len = 0;
      endcase
      res.length = 7'(list_len);
      return res;
   endfunction

   // Drive one request at the falling edge, hold it until accepted, then
   // record the expected response. Unless steady is set, drop valid now and then.
   task automatic send_request(input ple_kind_type kind, input logic [6:0] pos,
                               input logic [31:0] val);
      list_result_type res;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {1'b0, val, pos};
      do @(posedge clock); while (!req_tready);
      res = apply_request(kind, pos, val);
      pending_results.push_back(res);
      kind_count[kind]++;
      status_count[res.status]++;
      if (list_len > longest_list) longest_list = list_len;
      if (!steady && $urandom_range(99) < 20) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(3)) @(negedge clock);
      end
   endtask

   // Random 32-bit value, with the signed extremes mixed in.
   function automatic logic [31:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 4) return 32'h7fff_ffff;
      if (r < 8) return 32'h8000_0000;
      if (r < 10) return 32'h0;
      return $urandom();
   endfunction

   // Mostly valid positions with the head and tail favored; the rest are
   // just past the range or anywhere in the field.
   function automatic logic [6:0] pick_position(ple_kind_type kind);
      int top;
      int r;
      top = (kind == KIND_INSERT) ? list_len + 1 : list_len;
      r = $urandom_range(99);
      if (kind == KIND_CLEAR || top == 0 || r < 8) return 7'($urandom_range(127));
      if (r < 12) return 7'(top + 1);
      if (r < 22) return 7'd1;
      if (r < 32) return 7'(top);
      return 7'($urandom_range(top, 1));
   endfunction

   task automatic test_empty_list();
      send_request(KIND_READ, 7'd1, pick_value());
      send_request(KIND_DELETE, 7'd1, pick_value());
      send_request(KIND_INSERT, 7'd0, pick_value());
      send_request(KIND_INSERT, 7'd2, pick_value());
      send_request(KIND_CLEAR, 7'd0, pick_value());
   endtask

   // Insert at the head, at the tail and in the middle, read back, then try positions past the end.
   task automatic test_insert_positions();
      int p;
      send_request(KIND_INSERT, 7'd1, 32'h7fff_ffff);
      send_request(KIND_INSERT, 7'd1, 32'h8000_0000);
      send_request(KIND_INSERT, 7'd3, 32'hffff_ffff);
      send_request(KIND_INSERT, 7'd2, 32'h0);
      for (p = 1; p <= 5; p++) send_request(KIND_READ, 7'(p), pick_value());
      send_request(KIND_DELETE, 7'd5, pick_value());
      send_request(KIND_INSERT, 7'd6, pick_value());
      send_request(KIND_READ, 7'd127, pick_value());
   endtask

   task automatic test_delete_positions();
      send_request(KIND_DELETE, 7'd1, pick_value());
      send_request(KIND_READ, 7'd1, pick_value());
      send_request(KIND_DELETE, 7'(list_len), pick_value());
      send_request(KIND_DELETE, 7'd0, pick_value());
      send_request(KIND_INSERT, 7'd2, pick_value());
      send_request(KIND_DELETE, 7'd2, pick_value());
      send_request(KIND_READ, 7'(list_len), pick_value());
      send_request(KIND_CLEAR, 7'd127, 32'hffff_ffff);
      send_request(KIND_READ, 7'd1, pick_value());
   endtask

   // Fill the list, hit it with full and out-of-range requests, then read, delete and insert at its ends.
   task automatic test_full_list();
      send_request(KIND_CLEAR, 7'd1, pick_value());
      while (list_len < DEPTH)
         send_request(KIND_INSERT, 7'($urandom_range(list_len + 1, 1)), pick_value());
      send_request(KIND_INSERT, 7'd1, pick_value());
      send_request(KIND_INSERT, 7'(DEPTH + 1), pick_value());
      send_request(KIND_INSERT, 7'(DEPTH + 2), pick_value());
      send_request(KIND_INSERT, 7'd127, pick_value());
      send_request(KIND_READ, 7'(DEPTH), pick_value());
      send_request(KIND_DELETE, 7'(DEPTH + 1), pick_value());
      send_request(KIND_DELETE, 7'(DEPTH), pick_value());
      send_request(KIND_INSERT, 7'(DEPTH), pick_value());
      send_request(KIND_DELETE, 7'd1, pick_value());
   endtask

   // Random requests with a given mix of clears, inserts and deletes (in
   // percent); the rest are reads.
   task automatic test_random_phase(input int n, input int clr_pct, input int ins_pct,
                                    input int del_pct);
      ple_kind_type kind;
      int k;
      int r;
      for (k = 0; k < n; k++) begin
         r = $urandom_range(99);
         if (r < clr_pct) kind = KIND_CLEAR;
         else if (r < clr_pct + ins_pct) kind = KIND_INSERT;
         else if (r < clr_pct + ins_pct + del_pct) kind = KIND_DELETE;
         else kind = KIND_READ;
         send_request(kind, pick_position(kind), pick_value());
      end
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
         errors++;
      end
   endtask

   // Compare each accepted response with the oldest expectation.
   always @(posedge clock) begin : response_check
      list_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response, expected none, got status %h data %h",
                     $time, rsp_tuser, rsp_tdata);
            errors++;
         end else begin
            want = pending_results.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_tuser));
            check_field("entry_value", want.value, rsp_tdata[31:0]);
            check_field("entry_tag", 32'(want.tag), 32'(rsp_tdata[38:32]));
            check_field("length", 32'(want.length), 32'(rsp_tdata[45:39]));
         end
      end
   end

   // Stall the response side at random about a fifth of the time, except in steady stretches.
   always @(negedge clock) begin
      rsp_tready <= !reset && (steady || $urandom_range(99) >= 20);
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time,
                  pending_results.size());
         $display("[positional_list_engine] ERROR");
         $finish;
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = KIND_INSERT;
      req_tdata  = '0;
      list_len   = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_insert_positions();
      test_delete_positions();
      test_full_list();
      // Grow toward full, run without idles, churn, then shrink.
      test_random_phase(300, 0, 60, 15);
      steady = 1'b1;
      test_random_phase(200, 2, 35, 30);
      steady = 1'b0;
      test_random_phase(400, 2, 35, 30);
      test_random_phase(200, 1, 15, 60);

      // Release the request side and wait for every response.
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d inserts, %0d deletes, %0d reads and %0d clears",
               kind_count[KIND_INSERT], kind_count[KIND_DELETE], kind_count[KIND_READ],
               kind_count[KIND_CLEAR]);
      $display("outcomes: %0d done, %0d bad position, %0d list full; longest list %0d",
               status_count[ST_DONE], status_count[ST_BAD_POS], status_count[ST_FULL],
               longest_list);
      if (errors == 0) begin
         $display("[positional_list_engine] OK");
      end else begin
         $display("[positional_list_engine] ERROR");
      end
      $finish;
   end

endmodule
